// ===== hw/rtl/grid_best_first_path_finder_defines.svh =====
// Assertion macros shared by the path finder RTL.
`ifndef GRID_BEST_FIRST_PATH_FINDER_DEFINES_SVH
`define GRID_BEST_FIRST_PATH_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define GBF_ASSERT_NOW(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define GBF_ASSERT_NEXT(lbl, ck, rn, pre, post, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/gbf_pkg.sv =====
// Shared types and constants of the grid path finder.
package gbf_pkg;

	localparam int GRID_W_DEF = 64;
	localparam int GRID_H_DEF = 64;

	localparam int COORD_W  = 6;
	localparam int LEN_W    = 12;
	localparam int WEIGHT_W = 4;

	localparam logic [LEN_W-1:0]    LEN_MAX      = '1;
	localparam logic [WEIGHT_W-1:0] G_WEIGHT_RST = 4'd8;
	localparam logic [WEIGHT_W-1:0] H_WEIGHT_RST = 4'd10;

	// Command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Register indexes
	localparam logic REG_G_WEIGHT = 1'b0;
	localparam logic REG_H_WEIGHT = 1'b1;

	// Move from parent to cell
	typedef enum logic [1:0] {
		DIR_XP = 2'd0,
		DIR_XN = 2'd1,
		DIR_YP = 2'd2,
		DIR_YN = 2'd3
	} dir_t;

	// One entry of the node memory
	typedef struct packed {
		logic wall;
		logic is_open;
		logic is_closed;
		dir_t dir;
	} node_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR_WB,
		ST_CLEAR,
		ST_INIT,
		ST_SCAN,
		ST_TAKE_RD,
		ST_TAKE_WB,
		ST_NB_RD,
		ST_NB_WB,
		ST_TRACE_RD,
		ST_TRACE_STEP,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/gbf_if.sv =====
// Channel interfaces of the path finder: request, response, register write.
interface gbf_req_if;
	import gbf_pkg::*;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic               wall_bit;
	logic [COORD_W-1:0] goal_x;
	logic [COORD_W-1:0] goal_y;
	modport source(output valid, cmd, cell_x, cell_y, wall_bit, goal_x, goal_y, input ready);
	modport sink(input valid, cmd, cell_x, cell_y, wall_bit, goal_x, goal_y, output ready);
endinterface

interface gbf_rsp_if;
	import gbf_pkg::*;
	logic               valid;
	logic               ready;
	logic               found;
	logic [COORD_W-1:0] next_x;
	logic [COORD_W-1:0] next_y;
	logic [LEN_W-1:0]   path_length;
	modport source(output valid, found, next_x, next_y, path_length, input ready);
	modport sink(input valid, found, next_x, next_y, path_length, output ready);
endinterface

interface gbf_cfg_if;
	import gbf_pkg::*;
	logic                valid;
	logic                ready;
	logic                index;
	logic [WEIGHT_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/gbf_score.sv =====
// Weighted Manhattan score of one cell against start and goal.
module gbf_score #(
	parameter int XW = 6,
	parameter int YW = 6,
	parameter int SW = ((XW > YW) ? XW : YW) + 1 + gbf_pkg::WEIGHT_W + 1
) (
	input  logic [XW-1:0]               px,
	input  logic [YW-1:0]               py,
	input  logic [XW-1:0]               sx,
	input  logic [YW-1:0]               sy,
	input  logic [XW-1:0]               gx,
	input  logic [YW-1:0]               gy,
	input  logic [gbf_pkg::WEIGHT_W-1:0] g_weight,
	input  logic [gbf_pkg::WEIGHT_W-1:0] h_weight,
	output logic [SW-1:0]               score
);
	import gbf_pkg::*;

	localparam int DW = ((XW > YW) ? XW : YW) + 1;
	localparam int PW = SW - 1;

	logic [XW-1:0] dxs, dxg;
	logic [YW-1:0] dys, dyg;
	logic [DW-1:0] dist_s, dist_g;
	logic [PW-1:0] prod_s, prod_g;

	// Distances from start and to goal
	always_comb begin
		dxs = (px > sx) ? (px - sx) : (sx - px);
		dys = (py > sy) ? (py - sy) : (sy - py);
		dxg = (px > gx) ? (px - gx) : (gx - px);
		dyg = (py > gy) ? (py - gy) : (gy - py);
		dist_s = DW'(dxs) + DW'(dys);
		dist_g = DW'(dxg) + DW'(dyg);
	end

	// Weighted sum
	assign prod_s = PW'(g_weight) * PW'(dist_s);
	assign prod_g = PW'(h_weight) * PW'(dist_g);
	assign score  = SW'(prod_s) + SW'(prod_g);
endmodule

// ===== hw/rtl/grid_best_first_path_finder.sv =====
// Grid best-first path finder: wall map writes and A*-style searches on a grid.
//
// A search first sweeps the node memory once, then for each expanded cell scans
// the open list one entry per cycle, removes the cell from it and visits its four
// neighbours; the path is then walked back to the start. The node memory and
// the open list each have one read and one write port. After reset a clearing
// pass zeroes the wall map; no request is taken during it, while register
// writes are. One search or write is in flight at a time; a finished result
// waits in the output register.
`include "grid_best_first_path_finder_defines.svh"

module grid_best_first_path_finder #(
	parameter int GRID_W = gbf_pkg::GRID_W_DEF,
	parameter int GRID_H = gbf_pkg::GRID_H_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gbf_req_if.sink   req,
	gbf_rsp_if.source rsp,
	gbf_cfg_if.sink   cfg
);
	import gbf_pkg::*;

	localparam int XW    = $clog2(GRID_W);
	localparam int YW    = $clog2(GRID_H);
	localparam int CW    = XW + YW;
	localparam int DEPTH = 1 << CW;
	localparam int DW    = ((XW > YW) ? XW : YW) + 1;
	localparam int SW    = DW + WEIGHT_W + 1;
	localparam int OW    = CW + CW + SW;
	localparam int NW    = $bits(node_t);

	localparam logic [CW:0]   CNT_MAX = (CW + 1)'(DEPTH);
	localparam logic [XW-1:0] X_LAST  = XW'(GRID_W - 1);
	localparam logic [YW-1:0] Y_LAST  = YW'(GRID_H - 1);

	state_t state_q, state_d;

	// Registers and control
	logic [WEIGHT_W-1:0] g_weight_q, h_weight_q;
	logic                keep_q;
	logic [CW:0]         clr_q;
	logic                clr_v_s1;
	logic [CW-1:0]       clr_a_s1;
	logic [CW:0]         cnt_q;
	logic [CW-1:0]       seq_q;
	logic [CW:0]         k_q;
	logic                scan_v_s1;
	dir_t                d_q;
	logic                rsp_valid_q;

	// Payload
	logic [XW-1:0]    sx_q, gx_q;
	logic [YW-1:0]    sy_q, gy_q;
	logic [CW-1:0]    start_q, goal_q;
	logic             wb_q, wr_ok_q;
	logic [CW-1:0]    scan_k_s1;
	logic [CW-1:0]    bk_q, bcell_q;
	logic [SW-1:0]    bscore_q;
	logic [CW-1:0]    bseq_q;
	logic             nb_ok_s1;
	logic [CW-1:0]    nb_a_s1;
	logic [XW-1:0]    nbx_s1;
	logic [YW-1:0]    nby_s1;
	logic [CW-1:0]    cur_q, nxt_q;
	logic [LEN_W-1:0] len_q;
	logic             res_found_q;
	logic [COORD_W-1:0] res_x_q, res_y_q;
	logic [LEN_W-1:0]   res_len_q;
	logic             rsp_found_q;
	logic [COORD_W-1:0] rsp_x_q, rsp_y_q;
	logic [LEN_W-1:0]   rsp_len_q;

	// Memory ports
	logic          node_we;
	logic [CW-1:0] node_waddr, node_raddr;
	node_t         node_wdata, node_rdata;
	logic [NW-1:0] node_rdata_raw;
	logic          ol_we;
	logic [CW-1:0] ol_waddr, ol_raddr;
	logic [OW-1:0] ol_wdata, ol_rdata;

	// Decoded values
	logic          req_acc;
	logic          coords_ok, goal_ok;
	logic [CW-1:0] req_cell, req_goal;
	logic [CW-1:0] e_cell, e_seq;
	logic [SW-1:0] e_score;
	logic          e_better;
	logic [XW-1:0] bx, nbx, cx;
	logic [YW-1:0] by, nby, cy;
	logic          nb_valid;
	logic          nb_take, nb_new;
	logic [XW-1:0] par_x;
	logic [YW-1:0] par_y;
	logic [XW-1:0] sc_x;
	logic [YW-1:0] sc_y;
	logic [SW-1:0] sc_score;
	logic          rsp_load;
	logic          clr_end;

	gbf_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata_raw)
	);
	assign node_rdata = node_t'(node_rdata_raw);

	gbf_ram #(.WIDTH(OW), .DEPTH(DEPTH)) u_open_ram (
		.clk   (clk),
		.we    (ol_we),
		.waddr (ol_waddr),
		.wdata (ol_wdata),
		.raddr (ol_raddr),
		.rdata (ol_rdata)
	);

	gbf_score #(.XW(XW), .YW(YW), .SW(SW)) u_score (
		.px       (sc_x),
		.py       (sc_y),
		.sx       (sx_q),
		.sy       (sy_q),
		.gx       (gx_q),
		.gy       (gy_q),
		.g_weight (g_weight_q),
		.h_weight (h_weight_q),
		.score    (sc_score)
	);

	// Request decode
	assign req_acc   = req.valid && req.ready;
	assign coords_ok = (int'(req.cell_x) < GRID_W) && (int'(req.cell_y) < GRID_H);
	assign goal_ok   = (int'(req.goal_x) < GRID_W) && (int'(req.goal_y) < GRID_H);
	assign req_cell  = {YW'(req.cell_y), XW'(req.cell_x)};
	assign req_goal  = {YW'(req.goal_y), XW'(req.goal_x)};

	// Open list entry fields: {cell, seq, score}
	assign e_cell   = ol_rdata[OW-1 -: CW];
	assign e_seq    = ol_rdata[SW +: CW];
	assign e_score  = ol_rdata[SW-1:0];
	assign e_better = (scan_k_s1 == '0) || (e_score < bscore_q) ||
		((e_score == bscore_q) && (e_seq > bseq_q));

	// Neighbour of the expanded cell
	assign bx = bcell_q[XW-1:0];
	assign by = bcell_q[CW-1:XW];
	always_comb begin
		nbx      = bx;
		nby      = by;
		nb_valid = 1'b0;
		unique case (d_q)
			DIR_XP: begin
				nb_valid = (bx != X_LAST);
				nbx      = bx + 1'b1;
			end
			DIR_XN: begin
				nb_valid = (bx != '0);
				nbx      = bx - 1'b1;
			end
			DIR_YP: begin
				nb_valid = (by != Y_LAST);
				nby      = by + 1'b1;
			end
			DIR_YN: begin
				nb_valid = (by != '0);
				nby      = by - 1'b1;
			end
		endcase
	end

	assign nb_take = nb_ok_s1 && !node_rdata.is_closed && !node_rdata.wall;
	assign nb_new  = nb_take && !node_rdata.is_open;

	// Parent of the cell on the trace
	assign cx = cur_q[XW-1:0];
	assign cy = cur_q[CW-1:XW];
	always_comb begin
		par_x = cx;
		par_y = cy;
		unique case (node_rdata.dir)
			DIR_XP: par_x = cx - 1'b1;
			DIR_XN: par_x = cx + 1'b1;
			DIR_YP: par_y = cy - 1'b1;
			DIR_YN: par_y = cy + 1'b1;
		endcase
	end

	assign sc_x = (state_q == ST_INIT) ? sx_q : nbx_s1;
	assign sc_y = (state_q == ST_INIT) ? sy_q : nby_s1;

	assign clr_end  = (clr_q == CNT_MAX) && !clr_v_s1;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					if (req.cmd == CMD_WRITE) begin
						state_d = ST_WR_WB;
					end else if (coords_ok && goal_ok) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_WR_WB: state_d = ST_DONE;
			ST_CLEAR: begin
				if (clr_end) begin
					state_d = keep_q ? ST_INIT : ST_IDLE;
				end
			end
			ST_INIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if ((k_q == cnt_q) && !scan_v_s1) begin
					state_d = ST_TAKE_RD;
				end
			end
			ST_TAKE_RD: state_d = ST_TAKE_WB;
			ST_TAKE_WB: state_d = (bcell_q == goal_q) ? ST_TRACE_RD : ST_NB_RD;
			ST_NB_RD: state_d = ST_NB_WB;
			ST_NB_WB: begin
				if (d_q != DIR_YN) begin
					state_d = ST_NB_RD;
				end else if ((cnt_q == '0) && !nb_new) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_TRACE_RD: state_d = (cur_q == start_q) ? ST_DONE : ST_TRACE_STEP;
			ST_TRACE_STEP: state_d = ST_TRACE_RD;
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory controls and ready
	always_comb begin
		req.ready  = 1'b0;
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		node_raddr = '0;
		ol_we      = 1'b0;
		ol_waddr   = '0;
		ol_wdata   = '0;
		ol_raddr   = '0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready  = 1'b1;
				node_raddr = req_cell;
			end
			ST_WR_WB: begin
				node_we         = wr_ok_q;
				node_waddr      = start_q;
				node_wdata      = node_rdata;
				node_wdata.wall = wb_q;
			end
			ST_CLEAR: begin
				node_raddr           = clr_q[CW-1:0];
				node_we              = clr_v_s1;
				node_waddr           = clr_a_s1;
				node_wdata.wall      = keep_q && node_rdata.wall;
				node_wdata.is_open   = keep_q && (clr_a_s1 == start_q);
				node_wdata.is_closed = 1'b0;
				node_wdata.dir       = DIR_XP;
			end
			ST_INIT: begin
				ol_we    = 1'b1;
				ol_waddr = '0;
				ol_wdata = {start_q, CW'(0), sc_score};
			end
			ST_SCAN: begin
				ol_raddr = k_q[CW-1:0];
			end
			ST_TAKE_RD: begin
				ol_raddr   = CW'(cnt_q - 1'b1);
				node_raddr = bcell_q;
			end
			ST_TAKE_WB: begin
				ol_we                = 1'b1;
				ol_waddr             = bk_q;
				ol_wdata             = ol_rdata;
				node_we              = 1'b1;
				node_waddr           = bcell_q;
				node_wdata           = node_rdata;
				node_wdata.is_open   = 1'b0;
				node_wdata.is_closed = 1'b1;
			end
			ST_NB_RD: begin
				node_raddr = {nby, nbx};
			end
			ST_NB_WB: begin
				node_we              = nb_take;
				node_waddr           = nb_a_s1;
				node_wdata.wall      = 1'b0;
				node_wdata.is_open   = 1'b1;
				node_wdata.is_closed = 1'b0;
				node_wdata.dir       = d_q;
				ol_we                = nb_new;
				ol_waddr             = cnt_q[CW-1:0];
				ol_wdata             = {nb_a_s1, seq_q, sc_score};
			end
			ST_TRACE_RD: begin
				node_raddr = cur_q;
			end
			ST_TRACE_STEP, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			g_weight_q  <= G_WEIGHT_RST;
			h_weight_q  <= H_WEIGHT_RST;
			keep_q      <= 1'b0;
			clr_q       <= '0;
			clr_v_s1    <= 1'b0;
			cnt_q       <= '0;
			seq_q       <= '0;
			k_q         <= '0;
			scan_v_s1   <= 1'b0;
			d_q         <= DIR_XP;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Register writes
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_G_WEIGHT: g_weight_q <= cfg.data;
					REG_H_WEIGHT: h_weight_q <= cfg.data;
				endcase
			end

			// Output register
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					clr_q  <= '0;
					keep_q <= 1'b1;
				end
				ST_CLEAR: begin
					clr_v_s1 <= (clr_q != CNT_MAX);
					if (clr_q != CNT_MAX) begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_INIT: begin
					cnt_q     <= (CW + 1)'(1);
					seq_q     <= CW'(1);
					k_q       <= '0;
					scan_v_s1 <= 1'b0;
				end
				ST_SCAN: begin
					scan_v_s1 <= (k_q != cnt_q);
					if (k_q != cnt_q) begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_TAKE_RD: begin
					cnt_q <= cnt_q - 1'b1;
				end
				ST_TAKE_WB: begin
					d_q <= DIR_XP;
				end
				ST_NB_WB: begin
					if (nb_new) begin
						cnt_q <= cnt_q + 1'b1;
						seq_q <= seq_q + 1'b1;
					end
					d_q       <= dir_t'(d_q + 2'd1);
					k_q       <= '0;
					scan_v_s1 <= 1'b0;
				end
				ST_WR_WB, ST_NB_RD, ST_TRACE_RD, ST_TRACE_STEP, ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_found_q <= res_found_q;
			rsp_x_q     <= res_x_q;
			rsp_y_q     <= res_y_q;
			rsp_len_q   <= res_len_q;
		end

		unique case (state_q)
			ST_IDLE: begin
				sx_q        <= XW'(req.cell_x);
				sy_q        <= YW'(req.cell_y);
				gx_q        <= XW'(req.goal_x);
				gy_q        <= YW'(req.goal_y);
				start_q     <= req_cell;
				goal_q      <= req_goal;
				wb_q        <= req.wall_bit;
				wr_ok_q     <= coords_ok;
				res_found_q <= 1'b0;
				res_x_q     <= '0;
				res_y_q     <= '0;
				res_len_q   <= '0;
			end
			ST_CLEAR: begin
				clr_a_s1 <= clr_q[CW-1:0];
			end
			ST_SCAN: begin
				scan_k_s1 <= k_q[CW-1:0];
				if (scan_v_s1 && e_better) begin
					bk_q     <= scan_k_s1;
					bcell_q  <= e_cell;
					bscore_q <= e_score;
					bseq_q   <= e_seq;
				end
			end
			ST_TAKE_WB: begin
				cur_q <= goal_q;
				nxt_q <= goal_q;
				len_q <= '0;
			end
			ST_NB_RD: begin
				nb_ok_s1 <= nb_valid;
				nb_a_s1  <= {nby, nbx};
				nbx_s1   <= nbx;
				nby_s1   <= nby;
			end
			ST_TRACE_RD: begin
				if (cur_q == start_q) begin
					res_found_q <= 1'b1;
					res_x_q     <= COORD_W'(nxt_q[XW-1:0]);
					res_y_q     <= COORD_W'(nxt_q[CW-1:XW]);
					res_len_q   <= len_q;
				end
			end
			ST_TRACE_STEP: begin
				nxt_q <= cur_q;
				cur_q <= {par_y, par_x};
				if (len_q != LEN_MAX) begin
					len_q <= len_q + 1'b1;
				end
			end
			ST_WR_WB, ST_INIT, ST_TAKE_RD, ST_NB_WB, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Port drive
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.next_x      = rsp_x_q;
	assign rsp.next_y      = rsp_y_q;
	assign rsp.path_length = rsp_len_q;

	// Checks
	`GBF_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_MAX, "open count beyond depth")
	`GBF_ASSERT_NOW(a_clear_blocks_req, clk, arst_n, state_q == ST_CLEAR, !req.ready, "request taken while clearing")
	`GBF_ASSERT_NOW(a_scan_nonempty, clk, arst_n, state_q == ST_SCAN, cnt_q != '0, "scan of empty open list")
	`GBF_ASSERT_NEXT(a_rsp_from_done, clk, arst_n, !rsp_valid_q && state_q != ST_DONE, !rsp_valid_q, "result shown outside done")

endmodule

// ===== bench/tb.sv =====
// Testbench of the grid best-first path finder: wall writes and searches checked against a predictor.
`timescale 1ns / 100ps

module tb;
	import gbf_pkg::*;

	localparam int          NCELL       = GRID_W_DEF * GRID_H_DEF;
	localparam longint      CYCLE_LIMIT = 20000000;

	// Expected response of one request
	typedef struct {
		logic               found;
		logic [COORD_W-1:0] next_x;
		logic [COORD_W-1:0] next_y;
		logic [LEN_W-1:0]   path_length;
	} path_rsp_t;

	logic clk;
	logic arst_n;

	gbf_req_if req_ch();
	gbf_rsp_if rsp_ch();
	gbf_cfg_if cfg_ch();

	grid_best_first_path_finder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source),
		.cfg    (cfg_ch.sink)
	);

	// Predictor state
	bit          wall_grid [NCELL];
	bit          closed_cell [NCELL];
	bit          open_cell [NCELL];
	dir_t        parent_dir [NCELL];
	int unsigned open_seq [NCELL];
	int unsigned open_list [NCELL];
	int unsigned open_total;
	int unsigned g_wt;
	int unsigned h_wt;

	path_rsp_t   pending_rsp[$];
	int          idle_pct;
	int          stall_pct;
	int          hold_left;
	int          mismatches;
	longint      cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** grid_best_first_path_finder: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned adiff(int unsigned a, int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic int unsigned node_score(int unsigned c, int unsigned sx,
			int unsigned sy, int unsigned gx, int unsigned gy);
		int unsigned x;
		int unsigned y;
		x = c % GRID_W_DEF;
		y = c / GRID_W_DEF;
		return g_wt * (adiff(x, sx) + adiff(y, sy)) +
			h_wt * (adiff(x, gx) + adiff(y, gy));
	endfunction

	// Best-first search over the predictor's wall map
	function automatic path_rsp_t find_path(int unsigned sx, int unsigned sy,
			int unsigned gx, int unsigned gy);
		path_rsp_t   r;
		int unsigned start_c, goal_c, seq, k, bk, bc, bf, f, c;
		int unsigned cx, cy, nx, ny, n, cur, nxt, len, px, py;
		dir_t        d;
		r = '{1'b0, '0, '0, '0};
		start_c = sy * GRID_W_DEF + sx;
		goal_c = gy * GRID_W_DEF + gx;
		seq = 0;
		for (int i = 0; i < NCELL; i++) begin
			closed_cell[i] = 0;
			open_cell[i] = 0;
		end
		open_total = 0;
		open_cell[start_c] = 1;
		open_seq[start_c] = seq++;
		open_list[open_total++] = start_c;
		while (open_total > 0) begin
			bk = 0;
			bc = open_list[0];
			bf = node_score(bc, sx, sy, gx, gy);
			for (k = 1; k < open_total; k++) begin
				c = open_list[k];
				f = node_score(c, sx, sy, gx, gy);
				if (f < bf || (f == bf && open_seq[c] > open_seq[bc])) begin
					bf = f;
					bk = k;
					bc = c;
				end
			end
			open_total--;
			open_list[bk] = open_list[open_total];
			open_cell[bc] = 0;
			closed_cell[bc] = 1;
			if (bc == goal_c) begin
				// walk parents back to the start
				cur = goal_c;
				nxt = goal_c;
				len = 0;
				while (cur != start_c && len < NCELL) begin
					px = cur % GRID_W_DEF;
					py = cur / GRID_W_DEF;
					nxt = cur;
					case (parent_dir[cur])
						DIR_XP: px--;
						DIR_XN: px++;
						DIR_YP: py--;
						default: py++;
					endcase
					cur = py * GRID_W_DEF + px;
					len++;
				end
				if (len > LEN_MAX)
					len = LEN_MAX;
				r.found = 1'b1;
				r.next_x = COORD_W'(nxt % GRID_W_DEF);
				r.next_y = COORD_W'(nxt / GRID_W_DEF);
				r.path_length = LEN_W'(len);
				return r;
			end
			cx = bc % GRID_W_DEF;
			cy = bc / GRID_W_DEF;
			d = d.first();
			for (int di = 0; di < 4; di++) begin
				nx = cx;
				ny = cy;
				case (d)
					DIR_XP: if (cx + 1 < GRID_W_DEF) nx = cx + 1;
					DIR_XN: if (cx > 0) nx = cx - 1;
					DIR_YP: if (cy + 1 < GRID_H_DEF) ny = cy + 1;
					default: if (cy > 0) ny = cy - 1;
				endcase
				n = ny * GRID_W_DEF + nx;
				// an edge move leaves the cell unchanged, which is closed
				if (!closed_cell[n] && !wall_grid[n]) begin
					parent_dir[n] = d;
					if (!open_cell[n]) begin
						open_cell[n] = 1;
						open_seq[n] = seq++;
						open_list[open_total++] = n;
					end
				end
				d = d.next();
			end
		end
		return r;
	endfunction

	// Send one request; predict its response on transfer
	task automatic send_req(logic cmd, int x, int y, logic wb, int gx, int gy);
		path_rsp_t r;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= cmd;
		req_ch.cell_x   <= COORD_W'(x);
		req_ch.cell_y   <= COORD_W'(y);
		req_ch.wall_bit <= wb;
		req_ch.goal_x   <= COORD_W'(gx);
		req_ch.goal_y   <= COORD_W'(gy);
		do @(posedge clk); while (!req_ch.ready);
		r = '{1'b0, '0, '0, '0};
		if (cmd == CMD_WRITE)
			wall_grid[y * GRID_W_DEF + x] = wb;
		else
			r = find_path(x, y, gx, gy);
		pending_rsp.push_back(r);
	endtask

	task automatic put_wall(int x, int y, logic wb);
		send_req(CMD_WRITE, x, y, wb, $urandom_range(63), $urandom_range(63));
	endtask

	task automatic search(int sx, int sy, int gx, int gy);
		send_req(CMD_SEARCH, sx, sy, 1'($urandom_range(1)), gx, gy);
	endtask

	// Lower valid and wait for every response
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= WEIGHT_W'(val);
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_G_WEIGHT)
			g_wt = val;
		else
			h_wt = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_weights(int g, int h);
		drain();
		write_reg(REG_G_WEIGHT, g);
		write_reg(REG_H_WEIGHT, h);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Response checker
	always @(posedge clk) begin
		path_rsp_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response at cycle %0d", cycles);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp_ch.found !== e.found || rsp_ch.next_x !== e.next_x ||
						rsp_ch.next_y !== e.next_y ||
						rsp_ch.path_length !== e.path_length) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp f=%0d nx=%0d ny=%0d len=%0d ",
							"got f=%0d nx=%0d ny=%0d len=%0d"},
							e.found, e.next_x, e.next_y, e.path_length, rsp_ch.found,
							rsp_ch.next_x, rsp_ch.next_y, rsp_ch.path_length);
				end
			end
		end
	end

	// Extremes of the fields and the named corner cases
	task automatic test_directed();
		put_wall(63, 63, 1'b1);
		put_wall(63, 63, 1'b0);
		search(0, 0, 0, 0);
		search(63, 63, 63, 63);
		search(0, 0, 63, 63);
		search(63, 0, 60, 2);
		search(0, 63, 3, 60);
		// start on a wall
		put_wall(5, 5, 1'b1);
		search(5, 5, 7, 5);
		put_wall(5, 5, 1'b0);
		// start boxed into the corner: no path, and goal on a wall
		put_wall(1, 0, 1'b1);
		put_wall(0, 1, 1'b1);
		search(0, 0, 40, 40);
		search(0, 0, 1, 0);
		put_wall(1, 0, 1'b0);
		put_wall(0, 1, 1'b0);
		// detour around a short wall
		put_wall(21, 20, 1'b1);
		search(20, 20, 23, 20);
		put_wall(21, 20, 1'b0);
		// all scores tie: the latest opened cell wins
		set_weights(0, 0);
		search(20, 20, 20, 19);
		search(30, 30, 30, 30);
		set_weights(int'(G_WEIGHT_RST), int'(H_WEIGHT_RST));
	endtask

	// Random writes and short searches under one weight setting
	task automatic test_random(int n, int g, int h, int idle, int stall);
		int sx, sy;
		set_weights(g, h);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) begin
			if ($urandom_range(99) < 35)
				put_wall($urandom_range(63), $urandom_range(63), $urandom_range(99) < 30);
			else begin
				sx = $urandom_range(63);
				sy = $urandom_range(63);
				search(sx, sy, $urandom_range(sx < 4 ? 0 : sx - 4, sx > 59 ? 63 : sx + 4),
					$urandom_range(sy < 4 ? 0 : sy - 4, sy > 59 ? 63 : sy + 4));
			end
		end
		drain();
	endtask

	// Long receiver hold-off while requests keep coming
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		@(posedge clk);
		hold_left = 400;
		repeat (8)
			put_wall($urandom_range(63), $urandom_range(63), 1'b0);
		search(10, 10, 12, 13);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_WRITE;
		req_ch.cell_x = '0;
		req_ch.cell_y = '0;
		req_ch.wall_bit = 1'b0;
		req_ch.goal_x = '0;
		req_ch.goal_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_G_WEIGHT;
		cfg_ch.data = '0;
		g_wt = G_WEIGHT_RST;
		h_wt = H_WEIGHT_RST;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		mismatches = 0;
		cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(15, int'(G_WEIGHT_RST), int'(H_WEIGHT_RST), 0, 0);
		test_random(15, 15, 15, 49, 0);
		test_random(15, 0, 15, 0, 49);
		test_random(15, 15, 0, 21, 21);
		test_random(10, 3, 12, 0, 0);
		test_backpressure();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("** grid_best_first_path_finder: PASSED **");
		else
			$display("** grid_best_first_path_finder: FAILED **");
		$finish;
	end

endmodule
